>>> rtl/pct_pkg.sv
// ----------------------------------------------------------------------------
// pct_pkg
// Shared types and codes for the polyline crossing test unit.
// ----------------------------------------------------------------------------
package pct_pkg;

    typedef enum logic [1:0] {
        ACT_LOAD_A = 2'd0,
        ACT_LOAD_B = 2'd1,
        ACT_TEST   = 2'd2,
        ACT_NONE   = 2'd3
    } pct_action_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_A0,
        ST_A1,
        ST_B0,
        ST_B1,
        ST_SEG,
        ST_DIFF,
        ST_MUL,
        ST_CMP
    } pct_state_t;

endpackage

>>> rtl/pct_ram.sv
// ----------------------------------------------------------------------------
// pct_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module pct_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/pct_seg_check.sv
// ----------------------------------------------------------------------------
// pct_seg_check
// Straddle test for segment P-Q against segment R-S: edge differences, then
// exact cross products, then the four side signs and the meet decision.
// ----------------------------------------------------------------------------
module pct_seg_check #(
    parameter int COORD_BITS = 16
) (
    input  logic                         clk,
    input  logic signed [COORD_BITS-1:0] p_x,
    input  logic signed [COORD_BITS-1:0] p_y,
    input  logic signed [COORD_BITS-1:0] q_x,
    input  logic signed [COORD_BITS-1:0] q_y,
    input  logic signed [COORD_BITS-1:0] r_x,
    input  logic signed [COORD_BITS-1:0] r_y,
    input  logic signed [COORD_BITS-1:0] s_x,
    input  logic signed [COORD_BITS-1:0] s_y,
    output logic                         meet
);

    localparam int DW = COORD_BITS + 1;
    localparam int PW = 2 * DW;
    localparam int SW = PW + 1;

    logic signed [DW-1:0] pxe, pye, qxe, qye, rxe, rye, sxe, sye;

    // Differences, registered.
    logic signed [DW-1:0] pq_x_reg, pq_y_reg, rp_x_reg, rp_y_reg, sp_x_reg, sp_y_reg;
    logic signed [DW-1:0] rs_x_reg, rs_y_reg, pr_x_reg, pr_y_reg, qr_x_reg, qr_y_reg;

    // Products, registered. Side value k is prod_a[k] - prod_b[k].
    logic signed [PW-1:0] prod_a_reg [4];
    logic signed [PW-1:0] prod_b_reg [4];

    logic signed [SW-1:0] side [4];
    logic [3:0]           side_neg;
    logic [3:0]           side_zero;
    logic                 same_ab;
    logic                 same_ba;

    assign pxe = $signed({p_x[COORD_BITS-1], p_x});
    assign pye = $signed({p_y[COORD_BITS-1], p_y});
    assign qxe = $signed({q_x[COORD_BITS-1], q_x});
    assign qye = $signed({q_y[COORD_BITS-1], q_y});
    assign rxe = $signed({r_x[COORD_BITS-1], r_x});
    assign rye = $signed({r_y[COORD_BITS-1], r_y});
    assign sxe = $signed({s_x[COORD_BITS-1], s_x});
    assign sye = $signed({s_y[COORD_BITS-1], s_y});

    always_ff @(posedge clk)
    begin
        pq_x_reg <= pxe - qxe;
        pq_y_reg <= pye - qye;
        rp_x_reg <= rxe - pxe;
        rp_y_reg <= rye - pye;
        sp_x_reg <= sxe - pxe;
        sp_y_reg <= sye - pye;
        rs_x_reg <= rxe - sxe;
        rs_y_reg <= rye - sye;
        pr_x_reg <= pxe - rxe;
        pr_y_reg <= pye - rye;
        qr_x_reg <= qxe - rxe;
        qr_y_reg <= qye - rye;
    end

    always_ff @(posedge clk)
    begin
        // R and S against line P-Q.
        prod_a_reg[0] <= rp_y_reg * pq_x_reg;
        prod_b_reg[0] <= rp_x_reg * pq_y_reg;
        prod_a_reg[1] <= sp_y_reg * pq_x_reg;
        prod_b_reg[1] <= sp_x_reg * pq_y_reg;
        // P and Q against line R-S.
        prod_a_reg[2] <= pr_y_reg * rs_x_reg;
        prod_b_reg[2] <= pr_x_reg * rs_y_reg;
        prod_a_reg[3] <= qr_y_reg * rs_x_reg;
        prod_b_reg[3] <= qr_x_reg * rs_y_reg;
    end

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            side[k] = $signed({prod_a_reg[k][PW-1], prod_a_reg[k]})
                    - $signed({prod_b_reg[k][PW-1], prod_b_reg[k]});
            side_neg[k]  = side[k][SW-1];
            side_zero[k] = (side[k] == '0);
        end
        same_ab = !side_zero[0] && !side_zero[1] && (side_neg[0] == side_neg[1]);
        same_ba = !side_zero[2] && !side_zero[3] && (side_neg[2] == side_neg[3]);
        meet    = !same_ab && !same_ba;
    end

endmodule

>>> rtl/polyline_crossing_test_unit.sv
// ----------------------------------------------------------------------------
// polyline_crossing_test_unit
// Two polylines in block RAM; a test walks the segment pairs until a pair
// meets and reports whether any segment of A meets a segment of B.
// ----------------------------------------------------------------------------
// Loads: one request per cycle while idle, written at the accepting edge, no result.
// Test: with a count below two, done rises in the next cycle. Otherwise the
// walk spends, per A segment, two A reads and the B pipeline fill, and per
// pair a capture, differences, products and compare, through the single
// read port of each RAM; done rises in the cycle after the compare of the
// first meeting pair or of the last pair. The receiver cannot stall. Reset
// clears control state; the RAMs are undefined until written.
module polyline_crossing_test_unit #(
    parameter int MAX_POINTS = 16,
    parameter int COORD_BITS = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic [1:0]                            action,
    input  logic [$clog2(MAX_POINTS)-1:0]         vertex_index,
    input  logic signed [COORD_BITS-1:0]          coord_x,
    input  logic signed [COORD_BITS-1:0]          coord_y,
    input  logic [$clog2(MAX_POINTS+1)-1:0]       count_a,
    input  logic [$clog2(MAX_POINTS+1)-1:0]       count_b,
    output logic                                  done,
    output logic                                  no_crossing
);

    import pct_pkg::*;

    localparam int IDX_W = $clog2(MAX_POINTS);
    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam int VW    = 2 * COORD_BITS;
    localparam logic [IDX_W:0]   MAX_IDX = MAX_POINTS[IDX_W:0];
    localparam logic [CNT_W-1:0] MAX_CNT = MAX_POINTS[CNT_W-1:0];
    localparam logic [CNT_W-1:0] TWO_CNT = CNT_W'(2);

    pct_state_t state_reg, state_next;

    logic [IDX_W-1:0] i_reg, i_next;
    logic [IDX_W-1:0] j_reg, j_next;
    logic [CNT_W-1:0] na_reg, na_next;
    logic [CNT_W-1:0] nb_reg, nb_next;
    logic             done_reg, done_next;
    logic             clear_reg, clear_next;

    logic signed [COORD_BITS-1:0] p_x_reg, p_y_reg, q_x_reg, q_y_reg;
    logic signed [COORD_BITS-1:0] r_x_reg, r_y_reg, s_x_reg, s_y_reg;

    logic             accept;
    logic             idx_ok;
    logic             we_a, we_b;
    logic [VW-1:0]    wdata;
    logic [IDX_W-1:0] raddr_a, raddr_b;
    logic [VW-1:0]    rdata_a, rdata_b;
    logic [CNT_W-1:0] sat_a, sat_b;
    logic [CNT_W:0]   i_plus2, j_plus2;
    logic             meet;

    assign accept = start && !busy;
    assign idx_ok = {1'b0, vertex_index} < MAX_IDX;
    assign wdata  = {coord_x, coord_y};
    // Writes happen only in idle and read data is captured only during a test,
    // so no captured read meets a write to the same entry in the same cycle.
    assign we_a   = accept && (action == ACT_LOAD_A) && idx_ok;
    assign we_b   = accept && (action == ACT_LOAD_B) && idx_ok;
    assign sat_a  = (count_a > MAX_CNT) ? MAX_CNT : count_a;
    assign sat_b  = (count_b > MAX_CNT) ? MAX_CNT : count_b;
    assign i_plus2 = (CNT_W+1)'(i_reg) + (CNT_W+1)'(2);
    assign j_plus2 = (CNT_W+1)'(j_reg) + (CNT_W+1)'(2);

    pct_ram #(
        .WIDTH (VW),
        .DEPTH (MAX_POINTS)
    ) u_ram_a (
        .clk   (clk),
        .we    (we_a),
        .waddr (vertex_index),
        .wdata (wdata),
        .raddr (raddr_a),
        .rdata (rdata_a)
    );

    pct_ram #(
        .WIDTH (VW),
        .DEPTH (MAX_POINTS)
    ) u_ram_b (
        .clk   (clk),
        .we    (we_b),
        .waddr (vertex_index),
        .wdata (wdata),
        .raddr (raddr_b),
        .rdata (rdata_b)
    );

    pct_seg_check #(
        .COORD_BITS (COORD_BITS)
    ) u_seg_check (
        .clk  (clk),
        .p_x  (p_x_reg),
        .p_y  (p_y_reg),
        .q_x  (q_x_reg),
        .q_y  (q_y_reg),
        .r_x  (r_x_reg),
        .r_y  (r_y_reg),
        .s_x  (s_x_reg),
        .s_y  (s_y_reg),
        .meet (meet)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            i_reg     <= '0;
            j_reg     <= '0;
            na_reg    <= '0;
            nb_reg    <= '0;
            done_reg  <= 1'b0;
            clear_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            na_reg    <= na_next;
            nb_reg    <= nb_next;
            done_reg  <= done_next;
            clear_reg <= clear_next;
        end
    end

    // Vertex registers capture RAM read data in the cycle after the address.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_A1)
        begin
            p_x_reg <= rdata_a[VW-1:COORD_BITS];
            p_y_reg <= rdata_a[COORD_BITS-1:0];
        end
        if (state_reg == ST_B0)
        begin
            q_x_reg <= rdata_a[VW-1:COORD_BITS];
            q_y_reg <= rdata_a[COORD_BITS-1:0];
        end
        if (state_reg == ST_B1)
        begin
            r_x_reg <= rdata_b[VW-1:COORD_BITS];
            r_y_reg <= rdata_b[COORD_BITS-1:0];
        end
        else if ((state_reg == ST_CMP) && !meet)
        begin
            r_x_reg <= s_x_reg;
            r_y_reg <= s_y_reg;
        end
        if (state_reg == ST_SEG)
        begin
            s_x_reg <= rdata_b[VW-1:COORD_BITS];
            s_y_reg <= rdata_b[COORD_BITS-1:0];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        na_next    = na_reg;
        nb_next    = nb_reg;
        done_next  = 1'b0;
        clear_next = clear_reg;
        raddr_a    = i_reg;
        raddr_b    = j_reg;
        busy       = 1'b1;

        unique case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
                if (start && (action == ACT_TEST))
                begin
                    na_next = sat_a;
                    nb_next = sat_b;
                    i_next  = '0;
                    if ((sat_a < TWO_CNT) || (sat_b < TWO_CNT))
                    begin
                        done_next  = 1'b1;
                        clear_next = 1'b1;
                    end
                    else
                    begin
                        state_next = ST_A0;
                    end
                end
            end
            ST_A0:
            begin
                raddr_a    = i_reg;
                state_next = ST_A1;
            end
            ST_A1:
            begin
                raddr_a    = i_reg + 1'b1;
                state_next = ST_B0;
            end
            ST_B0:
            begin
                j_next     = '0;
                raddr_b    = '0;
                state_next = ST_B1;
            end
            ST_B1:
            begin
                raddr_b    = j_reg + 1'b1;
                state_next = ST_SEG;
            end
            ST_SEG:
            begin
                state_next = ST_DIFF;
            end
            ST_DIFF:
            begin
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                raddr_b = IDX_W'(j_plus2);
                if (meet)
                begin
                    done_next  = 1'b1;
                    clear_next = 1'b0;
                    state_next = ST_IDLE;
                end
                else if (j_plus2 < {1'b0, nb_reg})
                begin
                    // Next B segment: the old end point becomes the start.
                    j_next     = j_reg + 1'b1;
                    state_next = ST_SEG;
                end
                else if (i_plus2 < {1'b0, na_reg})
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = ST_A0;
                end
                else
                begin
                    done_next  = 1'b1;
                    clear_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign done        = done_reg;
    assign no_crossing = clear_reg;

endmodule
